### hw/rtl/scb_pkg.sv
`timescale 1ns / 1ps

package scb_pkg;

  localparam int unsigned COORD_W    = 32;
  localparam int unsigned T_BITS     = 30;
  localparam int unsigned QUO_W      = T_BITS + 1;
  localparam int unsigned N_AXIS     = 3;
  localparam int unsigned N_LANE     = 2 * N_AXIS;
  localparam int unsigned N_CELL     = T_BITS;
  localparam int unsigned PIPE_DEPTH = N_CELL + 6;
  localparam int unsigned PROD_W     = COORD_W + QUO_W;
  localparam int unsigned ADDR_W     = 5;
  localparam int unsigned DATA_W     = 32;
  localparam int unsigned CNT_W      = $clog2(PIPE_DEPTH + 1);

  localparam logic [QUO_W-1:0]  T_ONE  = QUO_W'(64'd1 << T_BITS);
  localparam logic [QUO_W-1:0]  T_SAT  = QUO_W'((64'd1 << T_BITS) + 64'd1);
  localparam logic [PROD_W-1:0] T_HALF = PROD_W'(64'd1 << (T_BITS - 1));
  localparam logic [ADDR_W-1:0] ADDR_END = ADDR_W'(4 * N_LANE);

  typedef enum logic [2:0] {
    REG_MIN_X = 3'd0,
    REG_MIN_Y = 3'd1,
    REG_MIN_Z = 3'd2,
    REG_MAX_X = 3'd3,
    REG_MAX_Y = 3'd4,
    REG_MAX_Z = 3'd5
  } reg_idx_e;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic [COORD_W-1:0] mag_t;

  typedef struct packed {
    coord_t [N_AXIS-1:0] lo;
    coord_t [N_AXIS-1:0] hi;
  } box_t;

  typedef struct packed {
    logic neg;
    mag_t mag;
  } sdiff_t;

  typedef struct packed {
    mag_t             rem;
    logic [QUO_W-1:0] quo;
    logic             sat;
    logic             neg;
  } lane_t;

  typedef struct packed {
    coord_t [N_AXIS-1:0] start;
    coord_t [N_AXIS-1:0] stop;
    mag_t   [N_AXIS-1:0] delta;
    logic   [N_AXIS-1:0] dneg;
    logic   [N_AXIS-1:0] flat;
    logic   [N_AXIS-1:0] outside;
    lane_t  [N_LANE-1:0] lane;
  } item_t;

  function automatic sdiff_t abs_diff(coord_t x, coord_t y);
    logic [COORD_W:0] diff;
    logic [COORD_W:0] negd;
    sdiff_t r;
    diff  = {x[COORD_W-1], x} - {y[COORD_W-1], y};
    negd  = -diff;
    r.neg = diff[COORD_W];
    r.mag = r.neg ? negd[COORD_W-1:0] : diff[COORD_W-1:0];
    return r;
  endfunction

endpackage

### hw/rtl/scb_if.sv
`timescale 1ns / 1ps

interface scb_seg_if import scb_pkg::*; ();
  logic   valid;
  logic   ready;
  coord_t start_x;
  coord_t start_y;
  coord_t start_z;
  coord_t end_x;
  coord_t end_y;
  coord_t end_z;

  modport source (output valid, start_x, start_y, start_z, end_x, end_y, end_z,
                  input ready);
  modport sink (input valid, start_x, start_y, start_z, end_x, end_y, end_z,
                output ready);
endinterface

interface scb_clip_if import scb_pkg::*; ();
  logic   valid;
  logic   ready;
  logic   hit;
  coord_t clip_start_x;
  coord_t clip_start_y;
  coord_t clip_start_z;
  coord_t clip_end_x;
  coord_t clip_end_y;
  coord_t clip_end_z;

  modport source (output valid, hit, clip_start_x, clip_start_y, clip_start_z,
                  clip_end_x, clip_end_y, clip_end_z, input ready);
  modport sink (input valid, hit, clip_start_x, clip_start_y, clip_start_z,
                clip_end_x, clip_end_y, clip_end_z, output ready);
endinterface

### hw/rtl/scb_front.sv
`timescale 1ns / 1ps

module scb_front import scb_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  box_t                box_i,
  input  logic                valid_i,
  output logic                ready_o,
  input  coord_t [N_AXIS-1:0] start_i,
  input  coord_t [N_AXIS-1:0] stop_i,
  output logic                valid_o,
  input  logic                ready_i,
  output item_t               item_o
);

  logic                v1_q, v2_q;
  logic                rdy1, rdy2;
  coord_t [N_AXIS-1:0] s_q, e_q;
  mag_t   [N_AXIS-1:0] d_q;
  logic   [N_AXIS-1:0] dn_q;
  mag_t   [N_LANE-1:0] a_q;
  logic   [N_LANE-1:0] an_q;
  item_t               item_q, item_d;
  sdiff_t [N_AXIS-1:0] dd;
  sdiff_t [N_LANE-1:0] ad;

  assign rdy2    = !v2_q || ready_i;
  assign rdy1    = !v1_q || rdy2;
  assign ready_o = rdy1;
  assign valid_o = v2_q;
  assign item_o  = item_q;

  always_comb begin
    for (int i = 0; i < N_AXIS; i++) begin
      dd[i]          = abs_diff(stop_i[i], start_i[i]);
      ad[i]          = abs_diff(box_i.lo[i], start_i[i]);
      ad[i + N_AXIS] = abs_diff(box_i.hi[i], start_i[i]);
    end
  end

  always_comb begin
    item_d.start = s_q;
    item_d.stop  = e_q;
    item_d.delta = d_q;
    item_d.dneg  = dn_q;
    for (int i = 0; i < N_AXIS; i++) begin
      item_d.flat[i]    = (d_q[i] == '0);
      item_d.outside[i] = (!an_q[i] && a_q[i] != '0) || an_q[i + N_AXIS];
    end
    for (int k = 0; k < N_LANE; k++) begin
      item_d.lane[k].sat = {1'b0, a_q[k]} >= {d_q[k % N_AXIS], 1'b0};
      item_d.lane[k].neg = an_q[k] ^ dn_q[k % N_AXIS];
      if (a_q[k] >= d_q[k % N_AXIS]) begin
        item_d.lane[k].rem = a_q[k] - d_q[k % N_AXIS];
        item_d.lane[k].quo = QUO_W'(1);
      end else begin
        item_d.lane[k].rem = a_q[k];
        item_d.lane[k].quo = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_q <= valid_i;
      end
      if (rdy2) begin
        v2_q <= v1_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1) begin
      s_q <= start_i;
      e_q <= stop_i;
      for (int i = 0; i < N_AXIS; i++) begin
        d_q[i]  <= dd[i].mag;
        dn_q[i] <= dd[i].neg;
      end
      for (int k = 0; k < N_LANE; k++) begin
        a_q[k]  <= ad[k].mag;
        an_q[k] <= ad[k].neg;
      end
    end
    if (rdy2) begin
      item_q <= item_d;
    end
  end

endmodule

### hw/rtl/scb_cell.sv
`timescale 1ns / 1ps

module scb_cell import scb_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  valid_i,
  output logic  ready_o,
  input  item_t item_i,
  output logic  valid_o,
  input  logic  ready_i,
  output item_t item_o
);

  logic             v_q;
  item_t            item_q, item_d;
  logic [COORD_W:0] r2;
  logic [COORD_W:0] den;
  logic [COORD_W:0] sub;

  assign ready_o = !v_q || ready_i;
  assign valid_o = v_q;
  assign item_o  = item_q;

  always_comb begin
    item_d = item_i;
    for (int k = 0; k < N_LANE; k++) begin
      r2  = {item_i.lane[k].rem, 1'b0};
      den = {1'b0, item_i.delta[k % N_AXIS]};
      sub = r2 - den;
      if (r2 >= den) begin
        item_d.lane[k].rem = sub[COORD_W-1:0];
      end else begin
        item_d.lane[k].rem = r2[COORD_W-1:0];
      end
      item_d.lane[k].quo = {item_i.lane[k].quo[QUO_W-2:0], r2 >= den};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (ready_o) begin
      v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o) begin
      item_q <= item_d;
    end
  end

endmodule

### hw/rtl/scb_back.sv
`timescale 1ns / 1ps

module scb_back import scb_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  output logic                ready_o,
  input  item_t               item_i,
  output logic                valid_o,
  input  logic                ready_i,
  output logic                hit_o,
  output coord_t [N_AXIS-1:0] clip_start_o,
  output coord_t [N_AXIS-1:0] clip_stop_o
);

  logic v1_q, v2_q, v3_q, v4_q;
  logic rdy1, rdy2, rdy3, rdy4;

  coord_t [N_AXIS-1:0] s1_q, e1_q, s2_q, e2_q, s3_q, e3_q;
  mag_t   [N_AXIS-1:0] d1_q, d2_q;
  logic   [N_AXIS-1:0] dn1_q, dn2_q, dn3_q;
  logic   [N_AXIS-1:0] miss1_q;
  logic   [N_AXIS-1:0] flat1_q;
  coord_t [N_AXIS-1:0] enter_q, leave_q;
  logic   [QUO_W-1:0]  tlo_q, thi_q;
  logic                hit2_q, hit3_q, hit_q;
  logic   [PROD_W-1:0] prod_q [N_LANE];
  coord_t [N_AXIS-1:0] cs_q, ce_q;

  coord_t [N_LANE-1:0] qv;
  coord_t [N_AXIS-1:0] enter_d, leave_d;
  coord_t [N_AXIS-1:0] lo_c, hi_c;
  coord_t              lo_a, lo_b, hi_a, hi_b, tlo, thi;
  logic                hit_d;
  coord_t [N_AXIS-1:0] cs_d, ce_d;

  assign rdy4    = !v4_q || ready_i;
  assign rdy3    = !v3_q || rdy4;
  assign rdy2    = !v2_q || rdy3;
  assign rdy1    = !v1_q || rdy2;
  assign ready_o = rdy1;
  assign valid_o = v4_q;
  assign hit_o   = hit_q;
  assign clip_start_o = cs_q;
  assign clip_stop_o  = ce_q;

  always_comb begin
    for (int k = 0; k < N_LANE; k++) begin
      logic [QUO_W-1:0] mag;
      mag = (item_i.lane[k].sat || item_i.lane[k].quo > T_SAT) ? T_SAT : item_i.lane[k].quo;
      qv[k] = item_i.lane[k].neg ? -coord_t'({1'b0, mag}) : coord_t'({1'b0, mag});
    end
    for (int i = 0; i < N_AXIS; i++) begin
      enter_d[i] = item_i.dneg[i] ? qv[i + N_AXIS] : qv[i];
      leave_d[i] = item_i.dneg[i] ? qv[i] : qv[i + N_AXIS];
    end
  end

  always_comb begin
    for (int i = 0; i < N_AXIS; i++) begin
      lo_c[i] = flat1_q[i] ? '0 : enter_q[i];
      hi_c[i] = flat1_q[i] ? coord_t'({1'b0, T_ONE}) : leave_q[i];
    end
    lo_a  = (lo_c[0] > lo_c[1]) ? lo_c[0] : lo_c[1];
    lo_b  = (lo_c[2] > coord_t'(0)) ? lo_c[2] : coord_t'(0);
    tlo   = (lo_a > lo_b) ? lo_a : lo_b;
    hi_a  = (hi_c[0] < hi_c[1]) ? hi_c[0] : hi_c[1];
    hi_b  = (hi_c[2] < coord_t'({1'b0, T_ONE})) ? hi_c[2] : coord_t'({1'b0, T_ONE});
    thi   = (hi_a < hi_b) ? hi_a : hi_b;
    hit_d = !(|miss1_q) && !(tlo > thi);
  end

  always_comb begin
    for (int i = 0; i < N_AXIS; i++) begin
      logic [PROD_W-1:0] r0, r1;
      mag_t              m0, m1;
      r0 = prod_q[i] + T_HALF;
      r1 = prod_q[i + N_AXIS] + T_HALF;
      m0 = r0[T_BITS +: COORD_W];
      m1 = r1[T_BITS +: COORD_W];
      if (hit3_q) begin
        cs_d[i] = dn3_q[i] ? s3_q[i] - m0 : s3_q[i] + m0;
        ce_d[i] = dn3_q[i] ? s3_q[i] - m1 : s3_q[i] + m1;
      end else begin
        cs_d[i] = s3_q[i];
        ce_d[i] = e3_q[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_q <= valid_i;
      end
      if (rdy2) begin
        v2_q <= v1_q;
      end
      if (rdy3) begin
        v3_q <= v2_q;
      end
      if (rdy4) begin
        v4_q <= v3_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1) begin
      s1_q    <= item_i.start;
      e1_q    <= item_i.stop;
      d1_q    <= item_i.delta;
      dn1_q   <= item_i.dneg;
      flat1_q <= item_i.flat;
      miss1_q <= item_i.flat & item_i.outside;
      enter_q <= enter_d;
      leave_q <= leave_d;
    end
    if (rdy2) begin
      s2_q   <= s1_q;
      e2_q   <= e1_q;
      d2_q   <= d1_q;
      dn2_q  <= dn1_q;
      tlo_q  <= tlo[QUO_W-1:0];
      thi_q  <= thi[QUO_W-1:0];
      hit2_q <= hit_d;
    end
    if (rdy3) begin
      s3_q   <= s2_q;
      e3_q   <= e2_q;
      dn3_q  <= dn2_q;
      hit3_q <= hit2_q;
      for (int i = 0; i < N_AXIS; i++) begin
        prod_q[i]          <= d2_q[i] * tlo_q;
        prod_q[i + N_AXIS] <= d2_q[i] * thi_q;
      end
    end
    if (rdy4) begin
      hit_q <= hit3_q;
      cs_q  <= cs_d;
      ce_q  <= ce_d;
    end
  end

endmodule

### hw/rtl/segment_box_clip.sv
`timescale 1ns / 1ps

// Clips a 3D segment against the axis-aligned box held in the six box registers, by the slab
// method, with Q16.16 coordinates. One segment is taken per cycle while the output is not
// stalled. Between input and output lies a divider chain of thirty identical cells, each producing
// one fraction bit of all six slab quotients, placed between a two-stage front end and a
// four-stage back end that narrows the window, scales the deltas and forms the clipped points.
// Box registers must be written over APB only while idle; the block itself does not enforce this.
module segment_box_clip import scb_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  scb_seg_if.sink           seg_i,
  scb_clip_if.source        clip_o
);

  box_t box_q;
  logic cfg_wr;

  item_t chain_item [N_CELL+1];
  logic  chain_v    [N_CELL+1];
  logic  chain_r    [N_CELL+1];

  coord_t [N_AXIS-1:0] cs, ce;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      box_q <= '0;
    end else if (cfg_wr) begin
      unique case (reg_idx_e'(paddr[4:2]))
        REG_MIN_X: box_q.lo[0] <= pwdata;
        REG_MIN_Y: box_q.lo[1] <= pwdata;
        REG_MIN_Z: box_q.lo[2] <= pwdata;
        REG_MAX_X: box_q.hi[0] <= pwdata;
        REG_MAX_Y: box_q.hi[1] <= pwdata;
        REG_MAX_Z: box_q.hi[2] <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx_e'(paddr[4:2]))
      REG_MIN_X: prdata = box_q.lo[0];
      REG_MIN_Y: prdata = box_q.lo[1];
      REG_MIN_Z: prdata = box_q.lo[2];
      REG_MAX_X: prdata = box_q.hi[0];
      REG_MAX_Y: prdata = box_q.hi[1];
      REG_MAX_Z: prdata = box_q.hi[2];
      default:   prdata = '0;
    endcase
  end

  scb_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .box_i   (box_q),
    .valid_i (seg_i.valid),
    .ready_o (seg_i.ready),
    .start_i ({seg_i.start_z, seg_i.start_y, seg_i.start_x}),
    .stop_i  ({seg_i.end_z, seg_i.end_y, seg_i.end_x}),
    .valid_o (chain_v[0]),
    .ready_i (chain_r[0]),
    .item_o  (chain_item[0])
  );

  for (genvar c = 0; c < N_CELL; c++) begin : g_cell
    scb_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (chain_v[c]),
      .ready_o (chain_r[c]),
      .item_i  (chain_item[c]),
      .valid_o (chain_v[c+1]),
      .ready_i (chain_r[c+1]),
      .item_o  (chain_item[c+1])
    );
  end

  scb_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (chain_v[N_CELL]),
    .ready_o      (chain_r[N_CELL]),
    .item_i       (chain_item[N_CELL]),
    .valid_o      (clip_o.valid),
    .ready_i      (clip_o.ready),
    .hit_o        (clip_o.hit),
    .clip_start_o (cs),
    .clip_stop_o  (ce)
  );

  assign clip_o.clip_start_x = cs[0];
  assign clip_o.clip_start_y = cs[1];
  assign clip_o.clip_start_z = cs[2];
  assign clip_o.clip_end_x   = ce[0];
  assign clip_o.clip_end_y   = ce[1];
  assign clip_o.clip_end_z   = ce[2];

endmodule

### hw/rtl/scb_checker.sv
`timescale 1ns / 1ps

module scb_checker import scb_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              psel,
  input logic              penable,
  input logic              pwrite,
  input logic [ADDR_W-1:0] paddr,
  input logic [DATA_W-1:0] pwdata,
  input logic [DATA_W-1:0] prdata,
  input logic              in_valid_i,
  input logic              in_ready_i,
  input logic              out_valid_i,
  input logic              out_ready_i,
  input logic              out_hit_i
);

  logic [CNT_W-1:0] cnt_q;
  logic             in_acc, out_acc;

  assign in_acc  = in_valid_i && in_ready_i;
  assign out_acc = out_valid_i && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_q + CNT_W'(in_acc) - CNT_W'(out_acc);
    end
  end

  a_no_orphan_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> cnt_q != '0)
    else $error("result shown with no request in flight");

  a_depth_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(PIPE_DEPTH))
    else $error("more requests in flight than pipeline stages");

  a_ready_when_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("input stalled while output register is empty");

  a_reg_readback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(psel && penable && pwrite) && $past(paddr) < ADDR_END && paddr == $past(paddr)
    |-> prdata == $past(pwdata))
    else $error("box register does not read back the written value");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_hit_i))
    else $error("stalled result changed");

endmodule

bind segment_box_clip scb_checker u_scb_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .psel        (psel),
  .penable     (penable),
  .pwrite      (pwrite),
  .paddr       (paddr),
  .pwdata      (pwdata),
  .prdata      (prdata),
  .in_valid_i  (seg_i.valid),
  .in_ready_i  (seg_i.ready),
  .out_valid_i (clip_o.valid),
  .out_ready_i (clip_o.ready),
  .out_hit_i   (clip_o.hit)
);
